FILE: rtl/core/mqlm_pkg.sv
`timescale 1ns / 1ps

package mqlm_pkg;

    localparam logic       OP_ENQUEUE   = 1'b0;
    localparam logic       OP_DEQUEUE   = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } mqlm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic req_ready;
        logic capture;
        logic enq_step;
        logic deq_empty;
        logic node_rd;
        logic deq_commit;
    } mqlm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_valid;
        logic out_free;
        logic is_deq;
        logic deq_ok;
    } mqlm_stat_t;

endpackage

FILE: rtl/core/mqlm_chan_if.sv
`timescale 1ns / 1ps

interface mqlm_req_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic        [3:0]  queue_id;
    logic signed [31:0] key_in;

    modport source (output valid, output operation, output queue_id, output key_in,
                    input ready);
    modport sink   (input valid, input operation, input queue_id, input key_in,
                    output ready);
endinterface

interface mqlm_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] key_out;

    modport source (output valid, output status, output key_out, input ready);
    modport sink   (input valid, input status, input key_out, output ready);
endinterface

FILE: rtl/core/mqlm_ctrl.sv
`timescale 1ns / 1ps

module mqlm_ctrl
    import mqlm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mqlm_stat_t stat,
    output mqlm_cmd_t  cmd
);

    mqlm_state_t state_reg;
    mqlm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (stat.out_free)
                begin
                    state_next = (stat.is_deq && stat.deq_ok) ? ST_EXEC : ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.req_ready = 1'b1;
                cmd.capture   = stat.req_valid;
            end
            ST_LOOKUP:
            begin
                // an item only finishes when the result register can take it
                if (stat.out_free)
                begin
                    cmd.enq_step  = !stat.is_deq;
                    cmd.deq_empty = stat.is_deq && !stat.deq_ok;
                    cmd.node_rd   = stat.is_deq && stat.deq_ok;
                end
            end
            ST_EXEC:
            begin
                cmd.deq_commit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/mqlm_dp.sv
`timescale 1ns / 1ps

module mqlm_dp
    import mqlm_pkg::*;
#(
    parameter int NUM_QUEUES = 10,
    parameter int POOL_NODES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mqlm_cmd_t          cmd,
    output mqlm_stat_t         stat,
    input  logic               req_valid,
    input  logic               req_operation,
    input  logic        [3:0]  req_queue_id,
    input  logic signed [31:0] req_key_in,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic        [1:0]  rsp_status,
    output logic signed [31:0] rsp_key_out
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW = $clog2(POOL_NODES);
    localparam int CW = $clog2(POOL_NODES + 1);

    // captured transaction
    logic          op_reg;
    logic [3:0]    qid_reg;
    logic [31:0]   key_reg;

    // queue table and node pool
    logic [AW-1:0] head_mem [NUM_QUEUES];
    logic [AW-1:0] tail_mem [NUM_QUEUES];
    logic [31:0]   node_key_mem [POOL_NODES];
    logic [AW-1:0] node_next_mem [POOL_NODES];

    logic [AW-1:0] head_rd_reg;
    logic [AW-1:0] tail_rd_reg;
    logic [31:0]   key_rd_reg;
    logic [AW-1:0] next_rd_reg;

    logic [NUM_QUEUES-1:0] nonempty_reg;
    logic [NUM_QUEUES-1:0] nonempty_next;
    logic [AW-1:0]         free_head_reg;
    logic [AW-1:0]         free_head_next;
    logic [CW-1:0]         free_count_reg;
    logic [CW-1:0]         free_count_next;
    // nodes handed out from the untouched part of the pool; the rest of the
    // free nodes sit on the recycled list through node_next
    logic [CW-1:0]         fresh_cnt_reg;
    logic [CW-1:0]         fresh_cnt_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_key_reg;

    logic [QW-1:0] qidx;
    logic          q_ok;
    logic          q_nonempty;
    logic          fresh_avail;
    logic [AW-1:0] alloc_node;
    logic          enq_ok;
    logic          enq_do;
    logic          load_result;

    logic          head_we;
    logic [AW-1:0] head_wd;
    logic          tail_we;
    logic          next_we;
    logic [AW-1:0] next_wa;
    logic [AW-1:0] next_wd;
    logic [AW-1:0] next_ra;

    assign qidx        = QW'(qid_reg);
    assign q_ok        = (32'(qid_reg) < NUM_QUEUES);
    assign q_nonempty  = q_ok && nonempty_reg[qidx];
    assign fresh_avail = (fresh_cnt_reg != CW'(POOL_NODES));
    assign alloc_node  = fresh_avail ? fresh_cnt_reg[AW-1:0] : free_head_reg;
    assign enq_ok      = q_ok && (free_count_reg != '0);
    assign enq_do      = cmd.enq_step && enq_ok;
    assign load_result = cmd.enq_step || cmd.deq_empty || cmd.deq_commit;

    always_comb
    begin
        stat.req_valid = req_valid;
        stat.out_free  = !out_valid_reg || rsp_ready;
        stat.is_deq    = (op_reg == OP_DEQUEUE);
        stat.deq_ok    = q_nonempty;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_operation;
            qid_reg <= req_queue_id;
            key_reg <= req_key_in;
        end
    end

    // memory write controls
    always_comb
    begin
        head_we = 1'b0;
        head_wd = alloc_node;
        tail_we = 1'b0;
        next_we = 1'b0;
        next_wa = tail_rd_reg;
        next_wd = alloc_node;
        if (enq_do)
        begin
            tail_we = 1'b1;
            if (q_nonempty)
            begin
                next_we = 1'b1;
            end
            else
            begin
                head_we = 1'b1;
            end
        end
        else if (cmd.deq_commit)
        begin
            next_we = 1'b1;
            next_wa = head_rd_reg;
            next_wd = free_head_reg;
            if (head_rd_reg != tail_rd_reg)
            begin
                head_we = 1'b1;
                head_wd = next_rd_reg;
            end
        end
    end

    // link port serves the free-list head at capture, the queue head later
    assign next_ra = cmd.capture ? free_head_reg : head_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            head_rd_reg <= head_mem[QW'(req_queue_id)];
            tail_rd_reg <= tail_mem[QW'(req_queue_id)];
        end
        if (head_we)
        begin
            head_mem[qidx] <= head_wd;
        end
        if (tail_we)
        begin
            tail_mem[qidx] <= alloc_node;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.node_rd)
        begin
            key_rd_reg <= node_key_mem[head_rd_reg];
        end
        if (enq_do)
        begin
            node_key_mem[alloc_node] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture || cmd.node_rd)
        begin
            next_rd_reg <= node_next_mem[next_ra];
        end
        if (next_we)
        begin
            node_next_mem[next_wa] <= next_wd;
        end
    end

    always_comb
    begin
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_cnt_next  = fresh_cnt_reg;
        if (enq_do)
        begin
            nonempty_next[qidx] = 1'b1;
            free_count_next     = free_count_reg - CW'(1);
            if (fresh_avail)
            begin
                fresh_cnt_next = fresh_cnt_reg + CW'(1);
            end
            else
            begin
                free_head_next = next_rd_reg;
            end
        end
        else if (cmd.deq_commit)
        begin
            if (head_rd_reg == tail_rd_reg)
            begin
                nonempty_next[qidx] = 1'b0;
            end
            free_head_next  = head_rd_reg;
            free_count_next = free_count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CW'(POOL_NODES);
            fresh_cnt_reg  <= '0;
        end
        else
        begin
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_cnt_reg  <= fresh_cnt_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq_step)
        begin
            out_status_reg <= enq_ok ? STATUS_OK : STATUS_FULL;
            out_key_reg    <= '0;
        end
        else if (cmd.deq_empty)
        begin
            out_status_reg <= STATUS_EMPTY;
            out_key_reg    <= '0;
        end
        else if (cmd.deq_commit)
        begin
            out_status_reg <= STATUS_OK;
            out_key_reg    <= key_rd_reg;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_status  = out_status_reg;
    assign rsp_key_out = out_key_reg;

endmodule

FILE: rtl/core/multi_queue_linked_manager_unit.sv
`timescale 1ns / 1ps
// Channel  Modport  Role       Payload
// req      sink     requests   operation, queue_id, key_in
// rsp      source   results    status, key_out
//
// Enqueue and rejected requests go idle -> lookup -> idle, loading the result in
// lookup; a dequeue goes idle -> lookup -> exec and loads the result in exec:
// the queue table read is registered, then it reads the head node's key and link.
// req.ready is high whenever the controller is idle, even with a result waiting.
// rst_n is asynchronous; the pool needs no clearing pass after reset.
// A stalled rsp holds the next request in its lookup step until the result goes.

module multi_queue_linked_manager_unit
    import mqlm_pkg::*;
#(
    parameter int NUM_QUEUES = 10,
    parameter int POOL_NODES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    mqlm_req_if.sink    req,
    mqlm_rsp_if.source  rsp
);

    mqlm_cmd_t  cmd;
    mqlm_stat_t stat;

    mqlm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mqlm_dp #(
        .NUM_QUEUES (NUM_QUEUES),
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_queue_id  (req.queue_id),
        .req_key_in    (req.key_in),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_status    (rsp.status),
        .rsp_key_out   (rsp.key_out)
    );

    assign req.ready = cmd.req_ready;

endmodule

FILE: rtl/core/mqlm_checker.sv
`timescale 1ns / 1ps

module mqlm_checker
    import mqlm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [31:0] key_out
);

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STATUS_OK || status == STATUS_EMPTY
                       || status == STATUS_FULL))
    else $error("undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != STATUS_OK) |-> (key_out == '0))
    else $error("key returned with a failing status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(key_out)))
    else $error("result changed while stalled");

endmodule

bind multi_queue_linked_manager_unit mqlm_checker u_mqlm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .key_out   (rsp.key_out)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mqlm_pkg::*;

    localparam int NUM_QUEUES = 10;
    localparam int POOL_NODES = 256;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] key;
    } deq_result_t;

    logic clk;
    logic rst_n;

    mqlm_req_if req_ch();
    mqlm_rsp_if rsp_ch();

    multi_queue_linked_manager_unit #(
        .NUM_QUEUES (NUM_QUEUES),
        .POOL_NODES (POOL_NODES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow of the queue manager
    logic [7:0]  q_head [NUM_QUEUES];
    logic [7:0]  q_tail [NUM_QUEUES];
    logic        q_live [NUM_QUEUES];
    logic [31:0] pool_key  [POOL_NODES];
    logic [7:0]  pool_link [POOL_NODES];
    logic [7:0]  free_first;
    logic [8:0]  free_nodes;

    deq_result_t pending_results[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        holding = 1'b0;
    int          hold_len = 0;
    event        hold_start;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        #400000;
        $display("testbench failed");
        $finish;
    end

    task automatic reset_shadow();
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            q_head[q] = '0;
            q_tail[q] = '0;
            q_live[q] = 1'b0;
        end
        for (int n = 0; n < POOL_NODES; n++)
        begin
            pool_key[n]  = '0;
            pool_link[n] = 8'(n + 1);
        end
        free_first = '0;
        free_nodes = 9'(POOL_NODES);
    endtask

    function automatic deq_result_t apply_queue_op(logic op, logic [3:0] qid,
                                                   logic [31:0] key);
        deq_result_t r;
        logic [7:0]  n;
        r.status = STATUS_OK;
        r.key    = '0;
        if (op == OP_ENQUEUE)
        begin
            if (qid >= NUM_QUEUES || free_nodes == 0)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                n = free_first;
                free_first = pool_link[n];
                free_nodes--;
                pool_key[n] = key;
                if (q_live[qid])
                    pool_link[q_tail[qid]] = n;
                else
                    q_head[qid] = n;
                q_tail[qid] = n;
                q_live[qid] = 1'b1;
            end
        end
        else
        begin
            if (qid >= NUM_QUEUES || !q_live[qid])
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                n = q_head[qid];
                r.key = pool_key[n];
                if (n == q_tail[qid])
                    q_live[qid] = 1'b0;
                else
                    q_head[qid] = pool_link[n];
                pool_link[n] = free_first;
                free_first = n;
                free_nodes++;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // one request transaction; the shadow is updated at acceptance
    task automatic send_op(logic op, logic [3:0] qid, logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.queue_id  <= qid;
        req_ch.key_in    <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_queue_op(op, qid, key));
    endtask

    task automatic send_random(int enq_pct);
        logic [3:0] qid;
        logic       op;
        if ($urandom_range(99) < 4)
            qid = 4'($urandom_range(15, NUM_QUEUES));
        else
            qid = 4'($urandom_range(NUM_QUEUES - 1));
        op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        send_op(op, qid, $urandom);
    endtask

    // receiver: random stalls, overridden by a long hold-off
    always @(posedge clk)
        rsp_ch.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);

    initial
    begin : hold_off
        forever
        begin
            @(hold_start);
            holding <= 1'b1;
            repeat (hold_len) @(posedge clk);
            holding <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        deq_result_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result status %0d key %0d",
                                        rsp_ch.status, rsp_ch.key_out));
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (rsp_ch.status !== exp_r.status || rsp_ch.key_out !== exp_r.key)
                    note_mismatch($sformatf("status exp %0d got %0d, key exp %0d got %0d",
                                            exp_r.status, rsp_ch.status,
                                            $signed(exp_r.key), rsp_ch.key_out));
            end
        end
    end

    // extremes of every field, empty and full answers, last node, ids out of range
    task automatic test_directed();
        send_op(OP_DEQUEUE, 4'd0,  32'h0);
        send_op(OP_DEQUEUE, 4'd15, 32'hffff_ffff);
        send_op(OP_ENQUEUE, 4'd15, 32'h1234_5678);
        send_op(OP_ENQUEUE, 4'd10, 32'h0);
        send_op(OP_DEQUEUE, 4'd10, 32'h0);
        send_op(OP_ENQUEUE, 4'd0,  32'h7fff_ffff);
        send_op(OP_ENQUEUE, 4'd0,  32'h8000_0000);
        send_op(OP_ENQUEUE, 4'd0,  32'h0000_0000);
        send_op(OP_ENQUEUE, 4'd9,  32'hffff_ffff);
        send_op(OP_ENQUEUE, 4'd9,  32'h0000_0001);
        send_op(OP_ENQUEUE, 4'd5,  32'h5a5a_a5a5);
        send_op(OP_DEQUEUE, 4'd5,  32'h0);
        send_op(OP_DEQUEUE, 4'd5,  32'h0);
        send_op(OP_ENQUEUE, 4'd5,  32'ha5a5_5a5a);
        send_op(OP_DEQUEUE, 4'd0,  32'h0);
        send_op(OP_ENQUEUE, 4'd0,  32'hdead_beef);
        send_op(OP_DEQUEUE, 4'd0,  32'h0);
        send_op(OP_DEQUEUE, 4'd0,  32'h0);
        send_op(OP_DEQUEUE, 4'd0,  32'h0);
        send_op(OP_DEQUEUE, 4'd0,  32'h0);
        send_op(OP_DEQUEUE, 4'd9,  32'h0);
        send_op(OP_DEQUEUE, 4'd9,  32'h0);
        send_op(OP_DEQUEUE, 4'd8,  32'h0);
        send_op(OP_DEQUEUE, 4'd5,  32'h0);
    endtask

    task automatic test_mixed_traffic(int count, int enq_pct);
        repeat (count)
            send_random(enq_pct);
    endtask

    // fill the pool past its limit, churn near full, then drain every queue
    task automatic test_pool_exhaustion();
        logic [3:0] qid;
        repeat (POOL_NODES + 6)
            send_op(OP_ENQUEUE, 4'($urandom_range(NUM_QUEUES - 1)), $urandom);
        test_mixed_traffic(60, 50);
        while (free_nodes != POOL_NODES)
        begin
            qid = 4'($urandom_range(NUM_QUEUES - 1));
            if (q_live[qid] || $urandom_range(7) == 0)
                send_op(OP_DEQUEUE, qid, $urandom);
        end
        send_op(OP_DEQUEUE, 4'($urandom_range(NUM_QUEUES - 1)), $urandom);
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_len = 300;
        -> hold_start;
        test_mixed_traffic(20, 60);
    endtask

    initial
    begin
        int waited;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ENQUEUE;
        req_ch.queue_id  = '0;
        req_ch.key_in    = '0;
        rsp_ch.ready     = 1'b0;
        reset_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 75;
        test_directed();
        test_mixed_traffic(300, 55);

        send_idle_pct = 75;
        recv_idle_pct = 20;
        test_pool_exhaustion();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_mixed_traffic(500, 50);

        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
